@@ design/chdma_pkg.sv @@
package chdma_pkg;

    localparam int ADDR_W      = 32;
    localparam int FLEN_W      = 24;
    localparam int SLOT_FW     = 3;
    localparam int FREE_W      = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [FLEN_W-1:0] MAX_CHUNK_RST = 24'd65536;

    typedef enum logic {
        OP_SUBMIT = 1'b0,
        OP_DONE   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        EV_FIRST  = 2'd0,
        EV_NEXT   = 2'd1,
        EV_FINISH = 2'd2
    } ev_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } bk_state_t;

    // Classified command handed from the front to the back
    typedef struct packed {
        op_t                 op;
        logic [SLOT_FW-1:0]  done_slot;
        logic [ADDR_W-1:0]   src;
        logic [ADDR_W-1:0]   dst;
        logic [FLEN_W-1:0]   len;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        ev_t                 ev;
        logic [SLOT_FW-1:0]  slot;
        logic [ADDR_W-1:0]   src;
        logic [ADDR_W-1:0]   dst;
        logic [FLEN_W-1:0]   len;
        logic [ADDR_W-1:0]   landed_dst;
        logic [FLEN_W-1:0]   landed_len;
        logic [FREE_W-1:0]   free;
    } res_t;

endpackage

@@ design/chdma_front.sv @@
module chdma_front
    import chdma_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic [ADDR_W-1:0]   src_addr,
    input  logic [ADDR_W-1:0]   dst_addr,
    input  logic [FLEN_W-1:0]   total_len,
    input  logic [SLOT_FW-1:0]  done_slot,
    input  q_stat_t             q_stat,
    output logic                push,
    output cmd_t                push_cmd
);

    localparam logic [7:0] SLOT_LIMIT = 8'(NUM_SLOTS);

    logic accept;
    logic slot_ok;

    always_comb
    begin
        in_stall = q_stat.full;
        accept   = in_valid && !q_stat.full;
        slot_ok  = 8'(done_slot) < SLOT_LIMIT;
        // drop chunk-done beats that name a slot beyond the ring
        push     = accept && ((op_t'(operation) == OP_SUBMIT) || slot_ok);

        push_cmd.op        = op_t'(operation);
        push_cmd.done_slot = done_slot;
        push_cmd.src       = src_addr;
        push_cmd.dst       = dst_addr;
        push_cmd.len       = total_len;
    end

endmodule

@@ design/chdma_queue.sv @@
module chdma_queue
    import chdma_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head_cmd,
    output q_stat_t stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);

endmodule

@@ design/chdma_back.sv @@
module chdma_back
    import chdma_pkg::*;
#(
    parameter int NUM_SLOTS = 8,
    parameter int LEN_BITS  = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               head_cmd,
    input  q_stat_t            q_stat,
    output logic               pop,
    input  logic [FLEN_W-1:0]  max_chunk_len,
    input  logic               out_stall,
    output logic               out_valid,
    output res_t               res
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [CNT_W-1:0]  ALL_FREE  = CNT_W'(NUM_SLOTS);

    typedef struct packed {
        logic [ADDR_W-1:0]   src;
        logic [ADDR_W-1:0]   dst;
        logic [LEN_BITS-1:0] done;
        logic [LEN_BITS-1:0] left;
        logic [LEN_BITS-1:0] step;
    } slot_entry_t;

    slot_entry_t slot_mem [NUM_SLOTS];

    bk_state_t          state_reg, state_next;
    cmd_t               cmd_reg;
    slot_entry_t        rd_entry_reg;
    logic [SLOT_W-1:0]  next_slot_reg, next_slot_next;
    logic [CNT_W-1:0]   free_reg, free_next;
    logic               out_valid_reg, out_valid_next;
    res_t               res_reg, res_next;

    logic                out_free;
    logic                retire;
    logic                is_submit;
    logic [SLOT_W-1:0]   done_idx;
    logic [SLOT_W-1:0]   wr_idx;
    slot_entry_t         wr_entry;
    logic [LEN_BITS-1:0] limit;
    logic [LEN_BITS-1:0] sub_len;
    logic [LEN_BITS-1:0] sub_step;
    logic [LEN_BITS-1:0] left_n;
    logic [LEN_BITS-1:0] done_n;
    logic [LEN_BITS-1:0] nstep;
    logic [ADDR_W-1:0]   landed;

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop    = 1'b0;
        retire = 1'b0;
        case (state_reg)
            BK_IDLE: pop    = !q_stat.empty;
            BK_EXEC: retire = out_free;
            default:
            begin
                pop    = 1'b0;
                retire = 1'b0;
            end
        endcase
    end

    // slot arithmetic
    always_comb
    begin
        is_submit = (cmd_reg.op == OP_SUBMIT);
        done_idx  = SLOT_W'(cmd_reg.done_slot);
        limit     = LEN_BITS'(max_chunk_len);
        sub_len   = LEN_BITS'(cmd_reg.len);
        sub_step  = (limit >= sub_len) ? sub_len : limit;

        left_n = (rd_entry_reg.left >= rd_entry_reg.step)
                 ? rd_entry_reg.left - rd_entry_reg.step : '0;
        done_n = rd_entry_reg.done + rd_entry_reg.step;
        nstep  = (limit >= left_n) ? left_n : limit;
        landed = rd_entry_reg.dst + ADDR_W'(rd_entry_reg.done);

        next_slot_next = next_slot_reg;
        free_next      = free_reg;
        wr_idx         = done_idx;
        wr_entry       = rd_entry_reg;
        res_next       = res_reg;

        if (is_submit)
        begin
            wr_idx         = next_slot_reg;
            wr_entry.src   = cmd_reg.src;
            wr_entry.dst   = cmd_reg.dst;
            wr_entry.done  = '0;
            wr_entry.left  = sub_len;
            wr_entry.step  = sub_step;
            next_slot_next = (next_slot_reg == LAST_SLOT) ? '0 : next_slot_reg + 1'b1;
            // overwrite in round-robin order even when no slot is free
            free_next      = (free_reg != '0) ? free_reg - 1'b1 : free_reg;

            res_next.ev         = EV_FIRST;
            res_next.slot       = SLOT_FW'(next_slot_reg);
            res_next.src        = cmd_reg.src;
            res_next.dst        = cmd_reg.dst;
            res_next.len        = FLEN_W'(sub_step);
            res_next.landed_dst = '0;
            res_next.landed_len = '0;
        end
        else
        begin
            wr_entry.done = done_n;
            wr_entry.left = left_n;
            res_next.slot       = SLOT_FW'(done_idx);
            res_next.landed_dst = landed;
            res_next.landed_len = FLEN_W'(rd_entry_reg.step);
            if (left_n == '0)
            begin
                free_next    = (free_reg < ALL_FREE) ? free_reg + 1'b1 : free_reg;
                res_next.ev  = EV_FINISH;
                res_next.src = '0;
                res_next.dst = '0;
                res_next.len = '0;
            end
            else
            begin
                wr_entry.step = nstep;
                res_next.ev   = EV_NEXT;
                res_next.src  = rd_entry_reg.src + ADDR_W'(done_n);
                res_next.dst  = rd_entry_reg.dst + ADDR_W'(done_n);
                res_next.len  = FLEN_W'(nstep);
            end
        end
        res_next.free = FREE_W'(free_next);

        out_valid_next = out_valid_reg;
        if (retire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            next_slot_reg <= '0;
            free_reg      <= ALL_FREE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (retire)
            begin
                next_slot_reg <= next_slot_next;
                free_reg      <= free_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head_cmd;
        end
        if (retire)
        begin
            res_reg <= res_next;
        end
    end

    // slot memory: one registered read port, one write port
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_entry_reg <= slot_mem[SLOT_W'(head_cmd.done_slot)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            slot_mem[wr_idx] <= wr_entry;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

@@ design/chunked_dma_slot_engine.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_stall  | operation, src_addr, dst_addr, total_len,
//          |                      | done_slot
// out      | out_valid / out_stall| event_res, slot, chunk_src, chunk_dst,
//          |                      | chunk_len, landed_dst, landed_len, slots_free
// cfg      | cfg_we               | cfg_wdata (max_chunk_len)
//
// The back takes one command at a time; its slot memory read is registered, so a
// command reads its slot in BK_IDLE and computes and writes back in BK_EXEC.
// To reach out_valid a command passes the queue, slot read and output registers.
// Async active-low reset: ring pointer to slot 0, all slots free, queue empty,
// max_chunk_len to 65536. Slot contents are not cleared.
// Up to 2 commands wait between front and back; in_stall rises only when
// that queue is full, and the output register drains while the back works.
module chunked_dma_slot_engine
    import chdma_pkg::*;
#(
    parameter int NUM_SLOTS = 8,
    parameter int LEN_BITS  = 24
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_we,
    input  logic [FLEN_W-1:0]   cfg_wdata,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic [ADDR_W-1:0]   src_addr,
    input  logic [ADDR_W-1:0]   dst_addr,
    input  logic [FLEN_W-1:0]   total_len,
    input  logic [SLOT_FW-1:0]  done_slot,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          event_res,
    output logic [SLOT_FW-1:0]  slot,
    output logic [ADDR_W-1:0]   chunk_src,
    output logic [ADDR_W-1:0]   chunk_dst,
    output logic [FLEN_W-1:0]   chunk_len,
    output logic [ADDR_W-1:0]   landed_dst,
    output logic [FLEN_W-1:0]   landed_len,
    output logic [FREE_W-1:0]   slots_free
);

    logic [FLEN_W-1:0] max_chunk_len_reg;

    q_stat_t q_stat;
    logic    push;
    cmd_t    push_cmd;
    logic    pop;
    cmd_t    head_cmd;
    res_t    res;

    // Hold the chunk limit. Software must write it only while the engine is idle; this block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chunk_len_reg <= MAX_CHUNK_RST;
        end
        else if (cfg_we)
        begin
            max_chunk_len_reg <= cfg_wdata;
        end
    end

    // Front: accept beats, drop out-of-range chunk-done beats, enqueue the rest.
    chdma_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .src_addr  (src_addr),
        .dst_addr  (dst_addr),
        .total_len (total_len),
        .done_slot (done_slot),
        .q_stat    (q_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Command queue decoupling the input handshake from slot processing.
    chdma_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    // Back: read the slot, open a slot on submit or advance offsets, issue a chunk or finish.
    chdma_back #(
        .NUM_SLOTS (NUM_SLOTS),
        .LEN_BITS  (LEN_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_cmd      (head_cmd),
        .q_stat        (q_stat),
        .pop           (pop),
        .max_chunk_len (max_chunk_len_reg),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .res           (res)
    );

    assign event_res  = res.ev;
    assign slot       = res.slot;
    assign chunk_src  = res.src;
    assign chunk_dst  = res.dst;
    assign chunk_len  = res.len;
    assign landed_dst = res.landed_dst;
    assign landed_len = res.landed_len;
    assign slots_free = res.free;

endmodule

@@ design/chdma_checker.sv @@
module chdma_checker
    import chdma_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input logic [1:0]          event_res,
    input logic [SLOT_FW-1:0]  slot,
    input logic [ADDR_W-1:0]   chunk_src,
    input logic [ADDR_W-1:0]   chunk_dst,
    input logic [FLEN_W-1:0]   chunk_len,
    input logic [ADDR_W-1:0]   landed_dst,
    input logic [FLEN_W-1:0]   landed_len,
    input logic [FREE_W-1:0]   slots_free
);

    // A stalled result beat stays and does not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(slot)
            && $stable(chunk_src) && $stable(chunk_dst) && $stable(chunk_len)
            && $stable(landed_dst) && $stable(landed_len) && $stable(slots_free))
        else $error("result beat changed while stalled");

    // A first chunk reports nothing landed.
    a_first_no_landing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_FIRST |-> landed_dst == '0 && landed_len == '0)
        else $error("first chunk reports landed data");

    // A finished transfer issues no chunk.
    a_finish_no_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_FINISH
            |-> chunk_src == '0 && chunk_dst == '0 && chunk_len == '0)
        else $error("finish carries a chunk");

    // The next chunk lands right after the one just completed.
    a_next_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_NEXT
            |-> chunk_dst == landed_dst + ADDR_W'(landed_len))
        else $error("next chunk is not contiguous");

endmodule

bind chunked_dma_slot_engine chdma_checker u_chdma_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_res  (event_res),
    .slot       (slot),
    .chunk_src  (chunk_src),
    .chunk_dst  (chunk_dst),
    .chunk_len  (chunk_len),
    .landed_dst (landed_dst),
    .landed_len (landed_len),
    .slots_free (slots_free)
);
